FILE: hdl/padt_pkg.sv
// ----------------------------------------------------------------------------
// padt_pkg
// Shared codes and types of the packet ack and delivery tracker.
// ----------------------------------------------------------------------------
package padt_pkg;

   localparam int SEQ_MAX_BITS = 32;
   localparam int TIME_BITS    = 32;
   localparam int CNT_BITS     = 8;

   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_RECV = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] KIND_SEND    = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_DELIV   = 2'd2;
   localparam logic [1:0] KIND_DROP    = 2'd3;

   localparam logic [1:0] CSR_SEND_ACKS    = 2'd0;
   localparam logic [1:0] CSR_PROCESS_ACKS = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT      = 2'd2;

   localparam logic [CNT_BITS-1:0] CNT_MAX = 8'd255;
   localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 32'd1000;

   typedef struct packed {
      logic [1:0]              op;
      logic [TIME_BITS-1:0]    now_time;
      logic [SEQ_MAX_BITS-1:0] rx_sequence;
      logic                    rx_has_ack;
      logic [SEQ_MAX_BITS-1:0] rx_ack_start;
      logic [CNT_BITS-1:0]     rx_ack_count;
   } cmd_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [SEQ_MAX_BITS-1:0] seq;
      logic                    has_ack;
      logic [SEQ_MAX_BITS-1:0] ack_start;
      logic [CNT_BITS-1:0]     ack_count;
      logic                    accepted;
      logic                    overflow;
      logic                    last;
   } res_type;

   typedef struct packed {
      logic                 send_acks;
      logic                 process_acks;
      logic [TIME_BITS-1:0] timeout_ticks;
   } cfg_type;

endpackage

FILE: hdl/packet_ack_delivery_tracker_top.sv
// ----------------------------------------------------------------------------
// packet_ack_delivery_tracker_top
// Sequence numbering, ack range collection and delivery notification for a
// packet link.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   req_*     in         req_valid / req_ready     opcode, time, rx seq, ack range
//   rsp_*     out        rsp_valid / rsp_ready     kind, seq, tx ack range, flags
//   csr_*     in         csr_write_enable          csr_index, csr_write_data
//
// A word is queued in the command queue, then the back end runs: a send through
// its send and finish states; a receive through receive, a read and evaluate state
// per ack walk step when it carries a range, then finish; a timeout check likewise.
// The walks go through the in-flight RAM one read per step.
// Reset is synchronous and empties both queues and the command queue.
// Either side may stall on its own: the command queue decouples the request
// side, the output register and a held-back result the response side.
// ----------------------------------------------------------------------------
module packet_ack_delivery_tracker_top #(
   parameter int FLIGHT_DEPTH    = 32,
   parameter int ACK_RANGE_DEPTH = 16,
   parameter int SEQ_BITS        = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [31:0]         req_now_time,
   input  logic [SEQ_BITS-1:0] req_rx_sequence,
   input  logic                req_rx_has_ack,
   input  logic [SEQ_BITS-1:0] req_rx_ack_start,
   input  logic [7:0]          req_rx_ack_count,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_result_kind,
   output logic [SEQ_BITS-1:0] rsp_sequence_res,
   output logic                rsp_tx_has_ack,
   output logic [SEQ_BITS-1:0] rsp_tx_ack_start,
   output logic [7:0]          rsp_tx_ack_count,
   output logic                rsp_accepted,
   output logic                rsp_overflow,
   output logic                rsp_last,
   // configuration
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_write_data
);

   padt_pkg::cfg_type cfg_ff;
   logic              cmd_valid;
   logic              cmd_ready;
   padt_pkg::cmd_type cmd;
   padt_pkg::res_type res;

   // hold the configuration registers; the user writes them only while idle (not enforced)
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.send_acks     <= 1'b1;
         cfg_ff.process_acks  <= 1'b1;
         cfg_ff.timeout_ticks <= padt_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            padt_pkg::CSR_SEND_ACKS:    cfg_ff.send_acks     <= csr_write_data[0];
            padt_pkg::CSR_PROCESS_ACKS: cfg_ff.process_acks  <= csr_write_data[0];
            padt_pkg::CSR_TIMEOUT:      cfg_ff.timeout_ticks <= csr_write_data;
            default: ;
         endcase
      end
   end

   // front: take words, drop unknown opcodes, queue commands
   padt_front #(.SEQ_BITS(SEQ_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_now_time     (req_now_time),
      .req_rx_sequence  (req_rx_sequence),
      .req_rx_has_ack   (req_rx_has_ack),
      .req_rx_ack_start (req_rx_ack_start),
      .req_rx_ack_count (req_rx_ack_count),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_ready        (cmd_ready)
   );

   // back: advance numbering, walk the queues, emit results
   padt_back #(
      .FLIGHT_DEPTH    (FLIGHT_DEPTH),
      .ACK_RANGE_DEPTH (ACK_RANGE_DEPTH),
      .SEQ_BITS        (SEQ_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .out_valid (rsp_valid),
      .out_res   (res),
      .out_ready (rsp_ready)
   );

   assign rsp_result_kind  = res.kind;
   assign rsp_sequence_res = res.seq[SEQ_BITS-1:0];
   assign rsp_tx_has_ack   = res.has_ack;
   assign rsp_tx_ack_start = res.ack_start[SEQ_BITS-1:0];
   assign rsp_tx_ack_count = res.ack_count;
   assign rsp_accepted     = res.accepted;
   assign rsp_overflow     = res.overflow;
   assign rsp_last         = res.last;

endmodule

FILE: hdl/padt_ram.sv
// ----------------------------------------------------------------------------
// padt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module padt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/padt_front.sv
// ----------------------------------------------------------------------------
// padt_front
// Accept request words, drop unknown opcodes, hold commands in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module padt_front #(
   parameter int SEQ_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [31:0]           req_now_time,
   input  logic [SEQ_BITS-1:0]   req_rx_sequence,
   input  logic                  req_rx_has_ack,
   input  logic [SEQ_BITS-1:0]   req_rx_ack_start,
   input  logic [7:0]            req_rx_ack_count,
   output logic                  cmd_valid,
   output padt_pkg::cmd_type     cmd,
   input  logic                  cmd_ready
);

   padt_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        cnt_ff;
   logic              push;
   logic              pop;
   padt_pkg::cmd_type new_cmd;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;
   assign push      = req_valid && req_ready &&
                      (req_opcode == padt_pkg::OP_SEND ||
                       req_opcode == padt_pkg::OP_RECV ||
                       req_opcode == padt_pkg::OP_TICK);

   always_comb begin
      new_cmd              = '0;
      new_cmd.op           = req_opcode;
      new_cmd.now_time     = req_now_time;
      new_cmd.rx_sequence  = padt_pkg::SEQ_MAX_BITS'(req_rx_sequence);
      new_cmd.rx_has_ack   = req_rx_has_ack;
      new_cmd.rx_ack_start = padt_pkg::SEQ_MAX_BITS'(req_rx_ack_start);
      new_cmd.rx_ack_count = req_rx_ack_count;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: hdl/padt_back.sv
// ----------------------------------------------------------------------------
// padt_back
// Execute commands: numbering, ack range queue, in-flight queue, ack and
// timeout walks. One result is held back so that the last one can be marked.
// ----------------------------------------------------------------------------
module padt_back #(
   parameter int FLIGHT_DEPTH    = 32,
   parameter int ACK_RANGE_DEPTH = 16,
   parameter int SEQ_BITS        = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  padt_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  padt_pkg::cmd_type cmd,
   output logic              cmd_ready,
   output logic              out_valid,
   output padt_pkg::res_type out_res,
   input  logic              out_ready
);

   localparam int FIW = $clog2(FLIGHT_DEPTH);
   localparam int FCW = $clog2(FLIGHT_DEPTH + 1);
   localparam int AIW = $clog2(ACK_RANGE_DEPTH);
   localparam int ACW = $clog2(ACK_RANGE_DEPTH + 1);
   localparam int FW  = SEQ_BITS + 32;
   localparam int AW  = SEQ_BITS + 8;

   typedef enum logic [2:0] {
      S_IDLE, S_SEND, S_RECV, S_WALK_RD, S_WALK_EV, S_TO_RD, S_TO_EV, S_FINISH
   } state_type;

   state_type         state_ff;
   padt_pkg::cmd_type cur_ff;
   logic [SEQ_BITS-1:0] next_tx_ff;
   logic [SEQ_BITS-1:0] next_exp_ff;
   logic [FIW-1:0]    f_head_ff;
   logic [FCW-1:0]    f_count_ff;
   logic [AIW-1:0]    a_head_ff;
   logic [ACW-1:0]    a_count_ff;
   logic [SEQ_BITS-1:0] tail_start_ff;
   logic [7:0]        tail_cnt_ff;
   logic [SEQ_BITS:0] nxt_ff;
   logic [SEQ_BITS:0] end_ff;
   padt_pkg::res_type pend_ff;
   logic              pend_valid_ff;
   padt_pkg::res_type out_ff;
   logic              out_valid_ff;

   logic              out_free;
   logic              push_ok;
   logic              emit_req;
   padt_pkg::res_type emit_res;
   logic              step_ok;
   logic              out_load;
   padt_pkg::res_type pend_last;

   logic              f_we;
   logic [FIW-1:0]    f_tail;
   logic [FIW:0]      f_sum;
   logic [FW-1:0]     f_rd;
   logic              f_rd_en;
   logic [SEQ_BITS-1:0] fs;
   logic [31:0]       ft;
   logic [SEQ_BITS:0] fsx;
   logic              f_full;
   logic              timed_out;

   logic              a_we;
   logic [AIW-1:0]    a_waddr;
   logic [AW-1:0]     a_wdata;
   logic [AW-1:0]     a_rd;
   logic              a_rd_en;
   logic [AIW:0]      a_sum;
   logic [AIW:0]      a_sum_m1;
   logic [AIW-1:0]    a_tail_new;
   logic [AIW-1:0]    a_tail_last;
   logic              a_pop;

   logic [SEQ_BITS-1:0] rxs;
   logic              rx_acc;
   logic              a_extend;
   logic              a_ovf;
   logic              walk_go;

   function automatic logic [FIW-1:0] f_inc(input logic [FIW-1:0] v);
      f_inc = (v == FIW'(FLIGHT_DEPTH - 1)) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [AIW-1:0] a_inc(input logic [AIW-1:0] v);
      a_inc = (v == AIW'(ACK_RANGE_DEPTH - 1)) ? '0 : v + 1'b1;
   endfunction

   assign cmd_ready = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;
   assign out_free  = !out_valid_ff || out_ready;
   assign push_ok   = !pend_valid_ff || out_free;
   assign step_ok   = !emit_req || push_ok;

   // load the output register from the held-back word
   assign out_load  = (emit_req && push_ok && pend_valid_ff) ||
                      ((state_ff == S_FINISH) && pend_valid_ff && out_free);

   always_comb begin
      pend_last      = pend_ff;
      pend_last.last = 1'b1;
   end

   // flight queue addressing
   assign f_sum   = (FIW+1)'(f_head_ff) + (FIW+1)'(f_count_ff);
   assign f_tail  = (f_sum >= (FIW+1)'(FLIGHT_DEPTH)) ?
                    FIW'(f_sum - (FIW+1)'(FLIGHT_DEPTH)) : FIW'(f_sum);
   assign f_full  = (f_count_ff >= FCW'(FLIGHT_DEPTH));
   assign f_we    = (state_ff == S_SEND) && step_ok && cfg.process_acks && !f_full;
   assign f_rd_en = (state_ff == S_WALK_RD) || (state_ff == S_TO_RD);
   assign fs      = f_rd[SEQ_BITS-1:0];
   assign ft      = f_rd[FW-1:SEQ_BITS];
   assign fsx     = {1'b0, fs};
   assign timed_out = ({1'b0, ft} + {1'b0, cfg.timeout_ticks}) < {1'b0, cur_ff.now_time};

   // ack range queue addressing
   assign a_sum       = (AIW+1)'(a_head_ff) + (AIW+1)'(a_count_ff);
   assign a_sum_m1    = a_sum - 1'b1;
   assign a_tail_new  = (a_sum >= (AIW+1)'(ACK_RANGE_DEPTH)) ?
                        AIW'(a_sum - (AIW+1)'(ACK_RANGE_DEPTH)) : AIW'(a_sum);
   assign a_tail_last = (a_sum_m1 >= (AIW+1)'(ACK_RANGE_DEPTH)) ?
                        AIW'(a_sum_m1 - (AIW+1)'(ACK_RANGE_DEPTH)) : AIW'(a_sum_m1);
   assign a_rd_en     = (state_ff == S_IDLE) && cmd_valid;
   assign a_pop       = cfg.send_acks && (a_count_ff != '0);

   assign rxs      = cur_ff.rx_sequence[SEQ_BITS-1:0];
   assign rx_acc   = (rxs >= next_exp_ff);
   assign a_extend = (a_count_ff != '0) && (tail_cnt_ff != padt_pkg::CNT_MAX) &&
                     ((tail_start_ff + SEQ_BITS'(tail_cnt_ff)) == rxs);
   assign a_ovf    = cfg.send_acks && rx_acc && !a_extend &&
                     (a_count_ff >= ACW'(ACK_RANGE_DEPTH));
   assign a_we     = (state_ff == S_RECV) && step_ok && cfg.send_acks && rx_acc && !a_ovf;
   assign a_waddr  = a_extend ? a_tail_last : a_tail_new;
   assign a_wdata  = a_extend ? {tail_start_ff, tail_cnt_ff + 8'd1} : {rxs, 8'd1};
   assign walk_go  = cfg.process_acks && cur_ff.rx_has_ack;

   // result raised by the current state, if any
   always_comb begin
      emit_req = 1'b0;
      emit_res = '0;
      case (state_ff)
         S_SEND: begin
            emit_req           = 1'b1;
            emit_res.kind      = padt_pkg::KIND_SEND;
            emit_res.seq       = padt_pkg::SEQ_MAX_BITS'(next_tx_ff);
            emit_res.has_ack   = a_pop;
            emit_res.ack_start = a_pop ? padt_pkg::SEQ_MAX_BITS'(a_rd[AW-1:8]) : '0;
            emit_res.ack_count = a_pop ? a_rd[7:0] : 8'd0;
            emit_res.overflow  = cfg.process_acks && f_full;
         end
         S_RECV: begin
            emit_req          = 1'b1;
            emit_res.kind     = padt_pkg::KIND_VERDICT;
            emit_res.seq      = padt_pkg::SEQ_MAX_BITS'(rxs);
            emit_res.accepted = rx_acc;
            emit_res.overflow = a_ovf;
         end
         S_WALK_EV: begin
            emit_req      = (fsx <= nxt_ff);
            emit_res.kind = (fsx < nxt_ff) ? padt_pkg::KIND_DROP : padt_pkg::KIND_DELIV;
            emit_res.seq  = padt_pkg::SEQ_MAX_BITS'(fs);
         end
         S_TO_EV: begin
            emit_req      = timed_out;
            emit_res.kind = padt_pkg::KIND_DROP;
            emit_res.seq  = padt_pkg::SEQ_MAX_BITS'(fs);
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   padt_ram #(.WIDTH(FW), .DEPTH(FLIGHT_DEPTH)) u_flight_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_tail),
      .wr_data ({cur_ff.now_time, next_tx_ff}),
      .rd_en   (f_rd_en),
      .rd_addr (f_head_ff),
      .rd_data (f_rd)
   );

   padt_ram #(.WIDTH(AW), .DEPTH(ACK_RANGE_DEPTH)) u_ack_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (a_rd_en),
      .rd_addr (a_head_ff),
      .rd_data (a_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_tx_ff    <= '0;
         next_exp_ff   <= '0;
         f_head_ff     <= '0;
         f_count_ff    <= '0;
         a_head_ff     <= '0;
         a_count_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (emit_req && push_ok) begin
            if (pend_valid_ff) begin
               out_ff <= pend_ff;
            end
            pend_ff       <= emit_res;
            pend_valid_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cur_ff <= cmd;
                  unique case (cmd.op)
                     padt_pkg::OP_SEND: state_ff <= S_SEND;
                     padt_pkg::OP_RECV: state_ff <= S_RECV;
                     default:           state_ff <= S_TO_RD;
                  endcase
               end
            end
            S_SEND: begin
               if (push_ok) begin
                  next_tx_ff <= next_tx_ff + 1'b1;
                  if (f_we) begin
                     f_count_ff <= f_count_ff + 1'b1;
                  end
                  if (a_pop) begin
                     a_head_ff  <= a_inc(a_head_ff);
                     a_count_ff <= a_count_ff - 1'b1;
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_RECV: begin
               if (push_ok) begin
                  if (rx_acc) begin
                     next_exp_ff <= rxs + 1'b1;
                  end
                  if (a_we) begin
                     if (a_extend) begin
                        tail_cnt_ff <= tail_cnt_ff + 8'd1;
                     end else begin
                        tail_start_ff <= rxs;
                        tail_cnt_ff   <= 8'd1;
                        a_count_ff    <= a_count_ff + 1'b1;
                     end
                  end
                  nxt_ff   <= {1'b0, cur_ff.rx_ack_start[SEQ_BITS-1:0]};
                  end_ff   <= {1'b0, cur_ff.rx_ack_start[SEQ_BITS-1:0]} +
                              (SEQ_BITS+1)'(cur_ff.rx_ack_count);
                  state_ff <= walk_go ? S_WALK_RD : S_FINISH;
               end
            end
            S_WALK_RD: begin
               state_ff <= ((nxt_ff < end_ff) && (f_count_ff != '0)) ? S_WALK_EV : S_FINISH;
            end
            S_WALK_EV: begin
               if (step_ok) begin
                  if (fsx <= nxt_ff) begin
                     f_head_ff  <= f_inc(f_head_ff);
                     f_count_ff <= f_count_ff - 1'b1;
                  end
                  if (fsx == nxt_ff) begin
                     nxt_ff <= nxt_ff + 1'b1;
                  end else if (fsx > nxt_ff) begin
                     nxt_ff <= fsx;
                  end
                  state_ff <= S_WALK_RD;
               end
            end
            S_TO_RD: begin
               state_ff <= (f_count_ff != '0) ? S_TO_EV : S_FINISH;
            end
            S_TO_EV: begin
               if (!timed_out) begin
                  state_ff <= S_FINISH;
               end else if (push_ok) begin
                  f_head_ff  <= f_inc(f_head_ff);
                  f_count_ff <= f_count_ff - 1'b1;
                  state_ff   <= S_TO_RD;
               end
            end
            S_FINISH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  out_ff        <= pend_last;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: hdl/padt_checker.sv
// ----------------------------------------------------------------------------
// padt_checker
// Port-level checks of the tracker's result stream.
// ----------------------------------------------------------------------------
module padt_checker #(
   parameter int SEQ_BITS = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_result_kind,
   input logic [SEQ_BITS-1:0] rsp_sequence_res,
   input logic                rsp_tx_has_ack,
   input logic                rsp_accepted,
   input logic                rsp_overflow,
   input logic                rsp_last
);

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sequence_res))
      else $error("stalled result word changed");

   // a send header is always the only word of its item
   a_send_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == padt_pkg::KIND_SEND |-> rsp_last)
      else $error("send header not marked last");

   // notices carry no verdict, overflow or ack range
   a_notice_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == padt_pkg::KIND_DELIV ||
                    rsp_result_kind == padt_pkg::KIND_DROP)
      |-> !rsp_accepted && !rsp_overflow && !rsp_tx_has_ack)
      else $error("notice carries stray flags");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word after reset");

endmodule

bind packet_ack_delivery_tracker_top padt_checker #(.SEQ_BITS(SEQ_BITS)) u_padt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_sequence_res (rsp_sequence_res),
   .rsp_tx_has_ack   (rsp_tx_has_ack),
   .rsp_accepted     (rsp_accepted),
   .rsp_overflow     (rsp_overflow),
   .rsp_last         (rsp_last)
);
